>>> hw/rtl/wsp_pkg.sv
package wsp_pkg;

  localparam int FRAC_BITS = 16;
  // Dividend width of the NDC divide: magnitude of a clip value times 2^FRAC_BITS.
  localparam int DIV_W     = 32 + FRAC_BITS;
  localparam int SAT_W     = 72;
  localparam logic signed [31:0] VIS_THRESH = 32'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [7:0] {
    CFG_WIDTH  = 8'd0,
    CFG_HEIGHT = 8'd1
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_PROJECT = 1'b1
  } req_type_e;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } out_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < SAT_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/wsp_dot.sv
module wsp_dot
  import wsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] m_x_i [3],
  input  logic signed [31:0] m_y_i [3],
  input  logic signed [31:0] m_z_i [3],
  input  logic signed [31:0] m_t_i [3],
  output logic               valid_o,
  output logic signed [31:0] clip_o [3]
);

  logic               vld1_q, vld2_q;
  logic signed [63:0] px_q [3];
  logic signed [63:0] py_q [3];
  logic signed [63:0] pz_q [3];
  logic signed [31:0] t_q  [3];
  logic signed [31:0] clip_d [3];
  logic signed [31:0] clip_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  // Products stage, one multiplier per term.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        px_q[r] <= 64'(pos_x_i) * 64'(m_x_i[r]);
        py_q[r] <= 64'(pos_y_i) * 64'(m_y_i[r]);
        pz_q[r] <= 64'(pos_z_i) * 64'(m_z_i[r]);
        t_q[r]  <= m_t_i[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip_d[r] = sat32(SAT_W'(px_q[r] >>> FRAC_BITS) + SAT_W'(py_q[r] >>> FRAC_BITS)
                      + SAT_W'(pz_q[r] >>> FRAC_BITS) + SAT_W'(t_q[r]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clip_q <= clip_d;
    end
  end

  assign valid_o = vld2_q;
  assign clip_o  = clip_q;

endmodule

>>> hw/rtl/wsp_div.sv
module wsp_div
  import wsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               tag_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               valid_o,
  output logic               tag_o,
  output logic signed [31:0] quo_o
);

  // Stage k holds the partial remainder and the dividend shifted k times,
  // quotient bits filling in from the bottom.
  logic              vld_q [DIV_W+1];
  logic              tag_q [DIV_W+1];
  logic              neg_q [DIV_W+1];
  logic [32:0]       rem_q [DIV_W+1];
  logic [DIV_W-1:0]  dvd_q [DIV_W+1];
  logic [31:0]       den_q [DIV_W+1];
  logic [31:0]       mag;
  logic              out_vld_q, out_tag_q;
  logic signed [31:0] quo_d, quo_q;
  logic [DIV_W-1:0]  q_fin;

  assign mag = num_i[31] ? 32'(-num_i) : 32'(num_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      neg_q[0] <= num_i[31];
      rem_q[0] <= '0;
      dvd_q[0] <= {mag, FRAC_BITS'(0)};
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    logic        take;

    assign trial = {rem_q[k][31:0], dvd_q[k][DIV_W-1]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign take  = (trial >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k+1] <= tag_q[k];
        neg_q[k+1] <= neg_q[k];
        den_q[k+1] <= den_q[k];
        rem_q[k+1] <= take ? diff : trial;
        dvd_q[k+1] <= {dvd_q[k][DIV_W-2:0], take};
      end
    end
  end

  assign q_fin = dvd_q[DIV_W];

  always_comb begin
    if (neg_q[DIV_W]) begin
      if (q_fin > DIV_W'(33'h0_8000_0000)) begin
        quo_d = S32_MIN;
      end else begin
        quo_d = 32'(-q_fin);
      end
    end else begin
      if (q_fin > DIV_W'(33'h0_7FFF_FFFF)) begin
        quo_d = S32_MAX;
      end else begin
        quo_d = q_fin[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[DIV_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_tag_q <= tag_q[DIV_W];
      quo_q     <= quo_d;
    end
  end

  assign valid_o = out_vld_q;
  assign tag_o   = out_tag_q;
  assign quo_o   = quo_q;

endmodule

>>> hw/rtl/wsp_screen.sv
module wsp_screen
  import wsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               visible_i,
  input  logic signed [31:0] nx_i,
  input  logic signed [31:0] ny_i,
  input  logic [12:0]        hw_i,
  input  logic [12:0]        hh_i,
  output logic               valid_o,
  output out_word_t          word_o
);

  localparam int SW = 50;

  logic               vld_a_q, vld_b_q, vis_a_q;
  logic signed [45:0] mx_q, my_q;
  logic signed [31:0] nx_q, ny_q;
  logic [12:0]        hw_q, hh_q;
  logic signed [SW-1:0] sx_w, sy_w;
  out_word_t          word_d, word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q    <= 46'($signed({1'b0, hw_i})) * 46'(nx_i);
      my_q    <= 46'($signed({1'b0, hh_i})) * 46'(ny_i);
      nx_q    <= nx_i;
      ny_q    <= ny_i;
      hw_q    <= hw_i;
      hh_q    <= hh_i;
      vis_a_q <= visible_i;
    end
  end

  assign sx_w = SW'(mx_q) + SW'(nx_q) + (SW'(hw_q) <<< FRAC_BITS);
  assign sy_w = SW'(ny_q) - SW'(my_q) + (SW'(hh_q) <<< FRAC_BITS);

  always_comb begin
    word_d.visible  = vis_a_q;
    word_d.screen_x = vis_a_q ? sat32(SAT_W'(sx_w)) : '0;
    word_d.screen_y = vis_a_q ? sat32(SAT_W'(sy_w)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = vld_b_q;
  assign word_o  = word_q;

endmodule

>>> hw/rtl/world_to_screen_projection.sv
// Channel | Direction | Handshake                  | Word
// in      | input     | in_valid_i / in_stall_o    | in_word_t (load or project)
// out     | output    | out_valid_o / out_stall_i  | out_word_t (visible, screen x/y)
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One word accepted per cycle while the output is not stalled. A project word
// runs through the bit-per-stage NDC divider, which works on Q16.16 values.
// A load word writes the matrix at acceptance and yields nothing.
// Reset clears the matrix and loads 640x480 into the window registers.
// The whole pipeline holds while the output word is stalled; nothing drops.
module world_to_screen_projection
  import wsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [13:0] cfg_data_i
);

  logic               en;
  logic               in_acc;
  logic signed [31:0] mat_q [16];
  logic [13:0]        width_q, height_q;

  // Stage 0: captured point plus a snapshot of rows 0, 1 and 3.
  logic               s0_vld_q;
  logic signed [31:0] s0_x_q, s0_y_q, s0_z_q;
  logic signed [31:0] m_x_q [3];
  logic signed [31:0] m_y_q [3];
  logic signed [31:0] m_z_q [3];
  logic signed [31:0] m_t_q [3];

  logic               dot_vld;
  logic signed [31:0] clip [3];

  // Stage before the divider: visibility decision.
  logic               dv_vld_q, dv_vis_q;
  logic signed [31:0] dv_cx_q, dv_cy_q, dv_cw_q;

  logic               dx_vld, dy_vld, dx_tag, dy_tag;
  logic signed [31:0] nx, ny;
  logic               scr_vld;
  out_word_t          scr_word;

  // Advance everything unless a finished word is waiting.
  assign en         = !(scr_vld && out_stall_i);
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 14'd640;
      height_q <= 14'd480;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Matrix store: load words write here as they are accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= '0;
      end
    end else if (in_acc && in_word_i.req_type == REQ_LOAD) begin
      mat_q[in_word_i.entry_index] <= in_word_i.entry_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_acc && in_word_i.req_type == REQ_PROJECT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_x_q <= in_word_i.pos_x;
      s0_y_q <= in_word_i.pos_y;
      s0_z_q <= in_word_i.pos_z;
      for (int r = 0; r < 3; r++) begin
        m_x_q[r] <= mat_q[(r == 2) ? 3 : r];
        m_y_q[r] <= mat_q[4 + ((r == 2) ? 3 : r)];
        m_z_q[r] <= mat_q[8 + ((r == 2) ? 3 : r)];
        m_t_q[r] <= mat_q[12 + ((r == 2) ? 3 : r)];
      end
    end
  end

  wsp_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_vld_q),
    .pos_x_i (s0_x_q),
    .pos_y_i (s0_y_q),
    .pos_z_i (s0_z_q),
    .m_x_i   (m_x_q),
    .m_y_i   (m_y_q),
    .m_z_i   (m_z_q),
    .m_t_i   (m_t_q),
    .valid_o (dot_vld),
    .clip_o  (clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= 1'b0;
    end else if (en) begin
      dv_vld_q <= dot_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_vis_q <= (clip[2] >= VIS_THRESH);
      dv_cx_q  <= clip[0];
      dv_cy_q  <= clip[1];
      dv_cw_q  <= clip[2];
    end
  end

  wsp_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_vld_q),
    .tag_i   (dv_vis_q),
    .num_i   (dv_cx_q),
    .den_i   (dv_cw_q),
    .valid_o (dx_vld),
    .tag_o   (dx_tag),
    .quo_o   (nx)
  );

  wsp_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_vld_q),
    .tag_i   (dv_vis_q),
    .num_i   (dv_cy_q),
    .den_i   (dv_cw_q),
    .valid_o (dy_vld),
    .tag_o   (dy_tag),
    .quo_o   (ny)
  );

  wsp_screen u_screen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (dx_vld),
    .visible_i (dx_tag),
    .nx_i      (nx),
    .ny_i      (ny),
    .hw_i      (width_q[13:1]),
    .hh_i      (height_q[13:1]),
    .valid_o   (scr_vld),
    .word_o    (scr_word)
  );

  assign out_valid_o = scr_vld;
  assign out_word_o  = scr_word;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

  a_hidden_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.visible) |->
      (out_word_o.screen_x == 32'sd0 && out_word_o.screen_y == 32'sd0))
    else $error("invisible point with nonzero screen coordinates");

  a_load_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.req_type == REQ_LOAD) |=> !s0_vld_q)
    else $error("load word entered the projection pipeline");

  a_dividers_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dx_vld == dy_vld) && (!dx_vld || dx_tag == dy_tag))
    else $error("divider lanes out of step");

endmodule
